// ===== rtl/core/rc5d_pkg.sv =====
// Shared types and constants of the RC-5 sampled decoder.
package rc5d_pkg;

    localparam int FRAME_BITS = 13;
    localparam int BITS_LEFT_W = 4;
    localparam int CODE_W = 11;
    localparam int STATUS_W = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [15:0] CODE_MASK = 16'h87FF;

    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REPEAT = 2'd2;

    localparam logic [1:0] REG_BIT_DELAY = 2'd0;
    localparam logic [1:0] REG_EDGE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_REPEAT_WINDOW = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [7:0] BIT_DELAY_RESET = 8'd3;
    localparam logic [7:0] EDGE_TIMEOUT_RESET = 8'd3;
    localparam logic [15:0] REPEAT_WINDOW_RESET = 16'd400;

    typedef struct packed {
        logic [7:0]  bit_delay_ticks;
        logic [7:0]  edge_timeout_ticks;
        logic [15:0] repeat_window_ticks;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [CODE_W-1:0]   code;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ===== rtl/core/rc5_ir_sampled_decoder_unit.sv =====
// Top level of the RC-5 infrared decoder driven by pin samples.
//
// Each input beat is either a pin sample tick (s_tuser = 0) or a read request
// (s_tuser = 1); the unit accepts one beat per clock cycle, and every beat is
// handled in the cycle it is accepted. A read produces one result beat in the
// next cycle through a single output register; a tick produces none. Input
// is stalled only while that output register holds a result that has not
// been taken. Bit delay, edge timeout and repeat window are counted in ticks
// and set through the APB port at addresses 0x0, 0x4 and 0x8. No clearing
// pass follows reset.
module rc5_ir_sampled_decoder_unit
    import rc5d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [0] pin_level
    input  logic                 s_tuser,  // [0] func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // [10:0] code
    output logic [STATUS_W-1:0]  m_tuser,  // [1:0] status
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t    cfg;
    result_t result;
    logic    beat;

    assign beat = s_tvalid && s_tready;

    rc5d_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rc5d_frame_fsm u_frame_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .beat      (beat),
        .func      (s_tuser),
        .pin_level (s_tdata[0]),
        .result    (result)
    );

    rc5d_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .result   (result),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/rc5d_cfg_regs.sv =====
// APB register file holding the decoder timing registers.
module rc5d_cfg_regs
    import rc5d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_delay_ticks <= BIT_DELAY_RESET;
            cfg_reg.edge_timeout_ticks <= EDGE_TIMEOUT_RESET;
            cfg_reg.repeat_window_ticks <= REPEAT_WINDOW_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_BIT_DELAY:     cfg_reg.bit_delay_ticks <= pwdata[7:0];
                REG_EDGE_TIMEOUT:  cfg_reg.edge_timeout_ticks <= pwdata[7:0];
                REG_REPEAT_WINDOW: cfg_reg.repeat_window_ticks <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BIT_DELAY:     prdata = {24'd0, cfg_reg.bit_delay_ticks};
            REG_EDGE_TIMEOUT:  prdata = {24'd0, cfg_reg.edge_timeout_ticks};
            REG_REPEAT_WINDOW: prdata = {16'd0, cfg_reg.repeat_window_ticks};
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/rc5d_frame_fsm.sv =====
// Frame state machine: edge timing, bit shifting, repeat check and code hold.
module rc5d_frame_fsm
    import rc5d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    beat,
    input  logic    func,
    input  logic    pin_level,
    output result_t result
);

    typedef enum logic [1:0] {
        PH_STANDBY  = 2'd0,
        PH_DELAYING = 2'd1,
        PH_WAITING  = 2'd2,
        PH_REPEAT   = 2'd3
    } phase_t;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_SEEN = 2'd1;
    localparam logic [1:0] MARK_CHECK = 2'd2;
    localparam logic [BITS_LEFT_W-1:0] BITS_FULL = BITS_LEFT_W'(FRAME_BITS);

    phase_t                 phase_reg, phase_next;
    logic [7:0]             tick_count_reg, tick_count_next;
    logic [BITS_LEFT_W-1:0] bits_left_reg, bits_left_next;
    logic                   last_level_reg, last_level_next;
    logic [FRAME_BITS-1:0]  shift_word_reg, shift_word_next;
    logic [FRAME_BITS-1:0]  held_code_reg, held_code_next;
    logic                   code_pending_reg, code_pending_next;
    logic [1:0]             repeat_mark_reg, repeat_mark_next;
    logic [15:0]            repeat_timer_reg, repeat_timer_next;
    logic                   active;
    logic [7:0]             tick_inc;
    logic [15:0]            held_masked;

    assign active = ~pin_level;
    assign tick_inc = tick_count_reg + 8'd1;
    assign held_masked = 16'(held_code_reg) & CODE_MASK;

    always_comb
    begin
        phase_next = phase_reg;
        tick_count_next = tick_count_reg;
        bits_left_next = bits_left_reg;
        last_level_next = last_level_reg;
        shift_word_next = shift_word_reg;
        held_code_next = held_code_reg;
        code_pending_next = code_pending_reg;
        repeat_mark_next = repeat_mark_reg;
        repeat_timer_next = repeat_timer_reg;
        result.valid = 1'b0;
        result.code = '0;
        result.status = STATUS_NONE;

        if (func == FUNC_TICK)
        begin
            unique case (phase_reg)
                PH_STANDBY:
                begin
                    if (active)
                        phase_next = PH_DELAYING;
                end
                PH_DELAYING:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc > cfg.bit_delay_ticks)
                    begin
                        tick_count_next = '0;
                        if (bits_left_reg == '0)
                        begin
                            bits_left_next = BITS_FULL;
                            phase_next = PH_REPEAT;
                        end
                        else
                        begin
                            last_level_next = active;
                            phase_next = PH_WAITING;
                        end
                    end
                end
                PH_WAITING:
                begin
                    if (active != last_level_reg)
                    begin
                        bits_left_next = bits_left_reg - 1'b1;
                        if (active)
                            shift_word_next[bits_left_next] = 1'b1;
                        tick_count_next = '0;
                        phase_next = PH_DELAYING;
                    end
                    else
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc > cfg.edge_timeout_ticks)
                        begin
                            tick_count_next = '0;
                            shift_word_next = '0;
                            bits_left_next = BITS_FULL;
                            phase_next = PH_STANDBY;
                        end
                    end
                end
                PH_REPEAT:
                begin
                    if (repeat_mark_reg != MARK_NONE)
                    begin
                        if (shift_word_reg == held_code_reg)
                        begin
                            repeat_timer_next = '0;
                            repeat_mark_next = MARK_SEEN;
                        end
                        else
                            repeat_mark_next = MARK_NONE;
                    end
                    if (repeat_mark_next == MARK_NONE && !code_pending_reg)
                    begin
                        held_code_next = shift_word_reg;
                        repeat_timer_next = '0;
                        repeat_mark_next = MARK_CHECK;
                        code_pending_next = 1'b1;
                    end
                    shift_word_next = '0;
                    phase_next = PH_STANDBY;
                end
                default: ;
            endcase

            if (repeat_timer_next < cfg.repeat_window_ticks)
                repeat_timer_next = repeat_timer_next + 16'd1;
            else
                repeat_mark_next = MARK_NONE;
        end
        else
        begin
            result.valid = 1'b1;
            if (code_pending_reg)
            begin
                result.code = held_masked[CODE_W-1:0];
                result.status = STATUS_NEW;
                code_pending_next = 1'b0;
            end
            else if (repeat_mark_reg == MARK_SEEN)
                result.status = STATUS_REPEAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STANDBY;
            tick_count_reg <= '0;
            bits_left_reg <= BITS_FULL;
            last_level_reg <= 1'b0;
            shift_word_reg <= '0;
            held_code_reg <= '0;
            code_pending_reg <= 1'b0;
            repeat_mark_reg <= MARK_NONE;
            repeat_timer_reg <= '0;
        end
        else if (beat)
        begin
            phase_reg <= phase_next;
            tick_count_reg <= tick_count_next;
            bits_left_reg <= bits_left_next;
            last_level_reg <= last_level_next;
            shift_word_reg <= shift_word_next;
            held_code_reg <= held_code_next;
            code_pending_reg <= code_pending_next;
            repeat_mark_reg <= repeat_mark_next;
            repeat_timer_reg <= repeat_timer_next;
        end
    end

endmodule

// ===== rtl/core/rc5d_out_reg.sv =====
// Result register between the decoder and the output stream.
module rc5d_out_reg
    import rc5d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 beat,
    input  result_t              result,
    output logic                 in_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser
);

    logic                valid_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [STATUS_W-1:0] status_reg;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata = M_TDATA_W'(code_reg);
    assign m_tuser = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (beat)
            valid_reg <= result.valid;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (beat && result.valid)
        begin
            code_reg <= result.code;
            status_reg <= result.status;
        end
    end

endmodule

// ===== rtl/core/rc5d_checker.sv =====
// Port-level checker for the decoder top level, with its bind.
module rc5d_checker
    import rc5d_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == FUNC_READ |=> m_tvalid)
        else $error("read beat gave no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_NONE || m_tuser == STATUS_NEW ||
                      m_tuser == STATUS_REPEAT))
        else $error("invalid status");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STATUS_NEW |-> m_tdata == '0)
        else $error("code set without a new code");

endmodule

bind rc5_ir_sampled_decoder_unit rc5d_checker u_rc5d_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
